### rtl/sist_pkg.sv
`timescale 1ns / 1ps
package sist_pkg;
   localparam int MAX_RANGES = 64;
   localparam int ITEM_BITS = 24;
   localparam int SLOT_BITS = $clog2(MAX_RANGES);
   localparam int CNT_BITS = $clog2(MAX_RANGES + 1);
   localparam int LEN_BITS = ITEM_BITS + 1;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   typedef struct packed {
      logic [ITEM_BITS-1:0] start;
      logic [LEN_BITS-1:0] len;
   } entry_type;
endpackage

### rtl/sist_ram.sv
`timescale 1ns / 1ps
module sist_ram import sist_pkg::*; (
   input  logic clock,
   input  logic wr_en,
   input  logic [SLOT_BITS-1:0] wr_addr,
   input  entry_type wr_data,
   input  logic [SLOT_BITS-1:0] rd_addr,
   output entry_type rd_data
);
   entry_type mem [MAX_RANGES];
   entry_type rd_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

### rtl/sorted_interval_set_table.sv
`timescale 1ns / 1ps
// Sorted interval set table.
// Keeps a set of item numbers as sorted disjoint ranges in one RAM.
// Request channel (req_valid/req_ready): req_cmd (0 insert, 1 remove,
// 2 or 3 query) and req_item_number. Response channel (rsp_valid/rsp_ready):
// one item per request with membership before the step, the range at the
// resulting slot, the range count after the step and a status code.
// One request is handled at a time. The binary search over the range starts
// takes up to ceil(log2(count+1)) probes, each a RAM read and a compare;
// then the floor and next entries are read, the RAM is updated and
// the reported entry is read back. An insert or remove that opens or closes
// a slot moves the entries above it, one range at a time, each read and
// then written. The next request is taken in the cycle after the response
// is accepted.
// Reset clears the range count and the controller; no clearing pass of the
// RAM is needed since entries at or above the count are never used.
// While the receiver stalls, the response is held and no new request is
// taken, so nothing is lost.
module sorted_interval_set_table import sist_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_cmd,
   input  logic [ITEM_BITS-1:0] req_item_number,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_was_member,
   output logic rsp_range_valid,
   output logic [ITEM_BITS-1:0] rsp_range_begin,
   output logic [LEN_BITS-1:0] rsp_range_length,
   output logic [ITEM_BITS-1:0] rsp_offset_in_range,
   output logic [SLOT_BITS-1:0] rsp_range_slot,
   output logic [CNT_BITS-1:0] rsp_ranges_in_use,
   output logic [1:0] rsp_status
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PROBE = 4'd1;
   localparam logic [3:0] S_PWAIT = 4'd2;
   localparam logic [3:0] S_FLOOR = 4'd3;
   localparam logic [3:0] S_NEXT = 4'd4;
   localparam logic [3:0] S_DECIDE = 4'd5;
   localparam logic [3:0] S_SHRD = 4'd6;
   localparam logic [3:0] S_SHWR = 4'd7;
   localparam logic [3:0] S_FIN = 4'd8;
   localparam logic [3:0] S_RPT = 4'd9;
   localparam logic [3:0] S_RPTW = 4'd10;
   localparam logic [3:0] S_OUT = 4'd11;

   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_OPEN = 2'd1;
   localparam logic [1:0] SH_CLOSE = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [CNT_BITS-1:0] used_ff, used_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [ITEM_BITS-1:0] x_ff, x_in;
   logic [CNT_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   entry_type fl_ff, fl_in;       // floor entry, later the reported entry
   logic has_fl_ff, has_fl_in;
   logic [CNT_BITS-1:0] p1_ff, p1_in; // floor index + 1
   // write-after-shift pending entry
   entry_type fw_ff, fw_in;
   logic [CNT_BITS-1:0] fwa_ff, fwa_in;
   logic fwe_ff, fwe_in;
   logic [1:0] sh_ff, sh_in;
   logic [CNT_BITS-1:0] k_ff, k_in, kend_ff, kend_in;
   logic [CNT_BITS-1:0] rs_ff, rs_in;   // slot to report
   logic [ITEM_BITS-1:0] off_ff, off_in;
   logic rv_ff, rv_in, mem_ff, mem_in;
   logic [1:0] st_ff, st_in;

   logic wr_en;
   logic [SLOT_BITS-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   sist_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [LEN_BITS-1:0] xe, fl_end;
   logic member;
   assign xe = {1'b0, x_ff};
   assign fl_end = {1'b0, fl_ff.start} + fl_ff.len;
   assign member = has_fl_ff && (xe < fl_end);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   // sequence one request
   always_comb begin
      logic adj_l, adj_r;
      logic [ITEM_BITS-1:0] offv;
      state_in = state_ff; used_in = used_ff; cmd_in = cmd_ff; x_in = x_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff; fl_in = fl_ff;
      has_fl_in = has_fl_ff; p1_in = p1_ff; fw_in = fw_ff; fwa_in = fwa_ff;
      fwe_in = fwe_ff; sh_in = sh_ff; k_in = k_ff; kend_in = kend_ff;
      rs_in = rs_ff; off_in = off_ff; rv_in = rv_ff; mem_in = mem_ff;
      st_in = st_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      rd_addr = mid_ff[SLOT_BITS-1:0];
      adj_l = 1'b0; adj_r = 1'b0; offv = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd; x_in = req_item_number;
               lo_in = '0; hi_in = used_ff;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in = lo_ff + ((hi_ff - lo_ff) >> 1);
               rd_addr = SLOT_BITS'(mid_in);
               state_in = S_PWAIT;
            end else begin
               p1_in = lo_ff;
               has_fl_in = (lo_ff != '0);
               mid_in = lo_ff - 1'b1;
               state_in = S_FLOOR;
            end
         end
         S_PWAIT: begin
            // read issued last cycle at mid
            state_in = S_PROBE;
         end
         S_FLOOR: begin
            // read of floor entry returns next cycle
            mid_in = p1_ff;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            fl_in = rd_data;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // rd_data now holds entry p1 (valid only if p1 < used)
            offv = x_ff - fl_ff.start;
            mem_in = member; rv_in = 1'b0; st_in = ST_OK; off_in = '0;
            sh_in = SH_NONE; fwe_in = 1'b0;
            adj_l = has_fl_ff && (xe == fl_end);
            adj_r = (p1_ff < used_ff) && ({1'b0, rd_data.start} == xe + 1'b1);
            state_in = S_FIN;
            if (cmd_ff == CMD_INSERT) begin
               if (member) begin
                  rv_in = 1'b1; rs_in = p1_ff - 1'b1; off_in = offv;
               end else if (adj_l && adj_r) begin
                  wr_en = 1'b1; wr_addr = SLOT_BITS'(p1_ff - 1'b1);
                  wr_data.start = fl_ff.start;
                  wr_data.len = fl_ff.len + 1'b1 + rd_data.len;
                  sh_in = SH_CLOSE; k_in = p1_ff; kend_in = used_ff - 1'b1;
                  rv_in = 1'b1; rs_in = p1_ff - 1'b1; off_in = offv;
               end else if (adj_l) begin
                  wr_en = 1'b1; wr_addr = SLOT_BITS'(p1_ff - 1'b1);
                  wr_data.start = fl_ff.start; wr_data.len = fl_ff.len + 1'b1;
                  rv_in = 1'b1; rs_in = p1_ff - 1'b1;
                  off_in = fl_ff.len[ITEM_BITS-1:0];
               end else if (adj_r) begin
                  wr_en = 1'b1; wr_addr = SLOT_BITS'(p1_ff);
                  wr_data.start = rd_data.start - 1'b1;
                  wr_data.len = rd_data.len + 1'b1;
                  rv_in = 1'b1; rs_in = p1_ff;
               end else if (used_ff >= CNT_BITS'(MAX_RANGES)) begin
                  st_in = ST_FULL;
               end else begin
                  fw_in.start = x_ff; fw_in.len = LEN_BITS'(1);
                  fwa_in = p1_ff; fwe_in = 1'b1;
                  sh_in = SH_OPEN; k_in = used_ff; kend_in = p1_ff;
                  rv_in = 1'b1; rs_in = p1_ff;
               end
            end else if (cmd_ff == CMD_REMOVE) begin
               if (!member) begin
                  st_in = ST_ABSENT;
               end else if (offv == '0) begin
                  rv_in = 1'b1; rs_in = p1_ff - 1'b1;
                  if (fl_ff.len > LEN_BITS'(1)) begin
                     wr_en = 1'b1; wr_addr = SLOT_BITS'(p1_ff - 1'b1);
                     wr_data.start = fl_ff.start + 1'b1;
                     wr_data.len = fl_ff.len - 1'b1;
                  end else begin
                     sh_in = SH_CLOSE; k_in = p1_ff - 1'b1;
                     kend_in = used_ff - 1'b1;
                  end
               end else if ({1'b0, offv} == fl_ff.len - 1'b1) begin
                  wr_en = 1'b1; wr_addr = SLOT_BITS'(p1_ff - 1'b1);
                  wr_data.start = fl_ff.start; wr_data.len = fl_ff.len - 1'b1;
                  rv_in = 1'b1; rs_in = p1_ff;
               end else if (used_ff >= CNT_BITS'(MAX_RANGES)) begin
                  st_in = ST_FULL;
               end else begin
                  wr_en = 1'b1; wr_addr = SLOT_BITS'(p1_ff - 1'b1);
                  wr_data.start = fl_ff.start; wr_data.len = {1'b0, offv};
                  fw_in.start = x_ff + 1'b1;
                  fw_in.len = fl_ff.len - {1'b0, offv} - 1'b1;
                  fwa_in = p1_ff; fwe_in = 1'b1;
                  sh_in = SH_OPEN; k_in = used_ff; kend_in = p1_ff;
                  rv_in = 1'b1; rs_in = p1_ff;
               end
            end else begin
               if (member) begin
                  rv_in = 1'b1; rs_in = p1_ff - 1'b1; off_in = offv;
               end
            end
            if (sh_in != SH_NONE) state_in = S_SHRD;
         end
         S_SHRD: begin
            // read source of the next move, or stop
            if ((sh_ff == SH_OPEN && k_ff > kend_ff) ||
                (sh_ff == SH_CLOSE && k_ff < kend_ff)) begin
               rd_addr = (sh_ff == SH_OPEN) ? SLOT_BITS'(k_ff - 1'b1)
                                            : SLOT_BITS'(k_ff + 1'b1);
               state_in = S_SHWR;
            end else begin
               used_in = (sh_ff == SH_OPEN) ? used_ff + 1'b1 : used_ff - 1'b1;
               state_in = S_FIN;
            end
         end
         S_SHWR: begin
            wr_en = 1'b1; wr_addr = SLOT_BITS'(k_ff); wr_data = rd_data;
            k_in = (sh_ff == SH_OPEN) ? k_ff - 1'b1 : k_ff + 1'b1;
            state_in = S_SHRD;
         end
         S_FIN: begin
            if (fwe_ff) begin
               wr_en = 1'b1; wr_addr = SLOT_BITS'(fwa_ff); wr_data = fw_ff;
               fwe_in = 1'b0;
            end
            state_in = S_RPT;
         end
         S_RPT: begin
            if (rv_ff && rs_ff < used_ff) begin
               rd_addr = SLOT_BITS'(rs_ff);
            end else begin
               rv_in = 1'b0;
            end
            state_in = S_RPTW;
         end
         S_RPTW: begin
            fl_in = rv_ff ? rd_data : '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // binary search compare, using data read at mid
      if (state_ff == S_PWAIT) begin
         if (rd_data.start <= x_ff) lo_in = mid_ff + 1'b1;
         else hi_in = mid_ff;
      end
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         fwe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         fwe_ff <= fwe_in;
      end
      cmd_ff <= cmd_in; x_ff <= x_in; lo_ff <= lo_in; hi_ff <= hi_in;
      mid_ff <= mid_in; fl_ff <= fl_in; has_fl_ff <= has_fl_in; p1_ff <= p1_in;
      fw_ff <= fw_in; fwa_ff <= fwa_in; sh_ff <= sh_in; k_ff <= k_in;
      kend_ff <= kend_in; rs_ff <= rs_in; off_ff <= off_in; rv_ff <= rv_in;
      mem_ff <= mem_in; st_ff <= st_in;
   end

   assign rsp_was_member = mem_ff;
   assign rsp_range_valid = rv_ff;
   assign rsp_range_begin = rv_ff ? fl_ff.start : '0;
   assign rsp_range_length = rv_ff ? fl_ff.len : '0;
   assign rsp_offset_in_range = rv_ff ? off_ff : '0;
   assign rsp_range_slot = rv_ff ? SLOT_BITS'(rs_ff) : '0;
   assign rsp_ranges_in_use = used_ff;
   assign rsp_status = st_ff;

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_BITS'(MAX_RANGES)) else $error("range count overflow");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while response held");
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> !rsp_range_valid)
      else $error("full status with range");
`endif
endmodule
